// File: rtl/mmcts_pkg.sv
package mmcts_pkg;

	localparam int unsigned MAX_TASKS_DEF = 31;
	localparam int unsigned TIME_BITS_DEF = 16;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned TASK_W   = 5;
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned COST_W   = 17;
	localparam int unsigned MASK_W   = 32;

	localparam logic [COST_W-1:0] COST_MAX       = 17'h1FFFF;
	localparam logic [TASK_W-1:0] TASK_COUNT_RST = 5'd31;
	localparam logic [TASK_W-1:0] FIRST_TASK     = 5'd1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SETUP = 3'd0,
		ACT_PROC  = 3'd1,
		ACT_CLEAR = 3'd2,
		ACT_MARK  = 3'd3,
		ACT_QUERY = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	// control from the sequencer to the compare unit
	typedef struct packed {
		logic clear;
		logic cand_valid;
	} scan_ctl_t;

	// best candidate seen so far
	typedef struct packed {
		logic              found;
		logic [TASK_W-1:0] task_id;
		logic [COST_W-1:0] cost;
	} best_t;

endpackage

// File: rtl/mmcts_if.sv
interface mmcts_in_if;
	import mmcts_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [TASK_W-1:0]   row_task;
	logic [TASK_W-1:0]   column_task;
	logic [TIME_W-1:0]   time_value;

	modport source (output valid, action, row_task, column_task, time_value, input ready);
	modport sink (input valid, action, row_task, column_task, time_value, output ready);
endinterface

interface mmcts_out_if;
	import mmcts_pkg::*;

	logic              valid;
	logic              ready;
	logic [TASK_W-1:0] chosen_task;
	logic [COST_W-1:0] arc_cost;
	logic              found;

	modport source (output valid, chosen_task, arc_cost, found, input ready);
	modport sink (input valid, chosen_task, arc_cost, found, output ready);
endinterface

// File: rtl/masked_min_cost_task_select_top.sv
// an update, clear or mark goes straight to S_DONE and loads the result register once it is free
// a query runs S_SCAN over tasks 1 to L, L = min(task_count, MAX_TASKS), then S_DRAIN and S_DONE
// the input is ready only in S_IDLE, so a new item is taken only once the last one is through
// in a scan the min unit's single adder and comparator take one setup and one processing entry a cycle
// reset: arst_n clears the scheduled mask, task_count to 31 and all handshake state
// setup and processing stores are not cleared and hold garbage until written
module masked_min_cost_task_select_top #(
	parameter int unsigned MAX_TASKS = mmcts_pkg::MAX_TASKS_DEF,
	parameter int unsigned TIME_BITS = mmcts_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mmcts_pkg::TASK_W-1:0] cfg_data,
	mmcts_in_if.sink                     req,
	mmcts_out_if.source                  rsp
);
	import mmcts_pkg::*;

	// side of the store actually reachable with 5-bit task fields
	localparam int unsigned SIDE_N     = (MAX_TASKS + 1 < MASK_W) ? MAX_TASKS + 1 : MASK_W;
	localparam int unsigned RW         = $clog2(SIDE_N);
	localparam int unsigned SETUP_DEPTH = 1 << (2 * RW);
	localparam int unsigned PROC_DEPTH  = 1 << RW;

	// configuration
	logic [TASK_W-1:0] task_count_q;

	// sequencer state
	state_t            state_q, state_d;
	logic [TASK_W-1:0] t_q;
	logic [TASK_W-1:0] last_q;
	logic [RW-1:0]     row_q;
	logic              row_ok_q;
	logic [MASK_W-1:0] sched_q;

	logic              in_accept;
	logic              issue;
	logic              out_load;
	logic              row_ok;
	logic              col_ok;
	logic [TASK_W-1:0] last_d;
	logic [TIME_BITS-1:0] tv;

	// stores
	logic [TIME_BITS-1:0] setup_mem [SETUP_DEPTH];
	logic [TIME_BITS-1:0] proc_mem  [PROC_DEPTH];
	logic [TIME_BITS-1:0] setup_rd_s1;
	logic [TIME_BITS-1:0] proc_rd_s1;
	logic                 cand_s1;
	logic [TASK_W-1:0]    task_s1;

	// compare unit
	scan_ctl_t ctl;
	best_t     best;

	// result register
	logic              out_valid_q;
	logic [TASK_W-1:0] chosen_q;
	logic [COST_W-1:0] cost_q;
	logic              found_q;

	assign in_accept = req.valid && req.ready;
	assign row_ok    = 32'(req.row_task) <= 32'(MAX_TASKS);
	assign col_ok    = 32'(req.column_task) <= 32'(MAX_TASKS);
	assign last_d    = (32'(task_count_q) > 32'(MAX_TASKS)) ? TASK_W'(MAX_TASKS) : task_count_q;
	assign tv        = TIME_BITS'(req.time_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= TASK_COUNT_RST;
		end else if (cfg_we) begin
			task_count_q <= cfg_data;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					state_d = (req.action == ACT_QUERY) ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				// last index issued this cycle, or nothing to scan
				if (t_q >= last_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_SCAN: begin
				issue = row_ok_q && (t_q <= last_q);
			end
			S_DRAIN: begin
			end
			S_DONE: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q     <= FIRST_TASK;
			sched_q <= '0;
			cand_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			// scheduled candidates are dropped here, task 0 is never issued
			cand_s1 <= issue && !sched_q[t_q];
			if (in_accept) begin
				t_q <= FIRST_TASK;
			end else if (state_q == S_SCAN) begin
				t_q <= t_q + FIRST_TASK;
			end
			if (in_accept) begin
				case (req.action)
					ACT_CLEAR: sched_q <= '0;
					ACT_MARK: begin
						if (col_ok) begin
							sched_q[req.column_task] <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// query context, captured on the transaction
	always_ff @(posedge clk) begin
		if (in_accept) begin
			last_q   <= last_d;
			row_q    <= req.row_task[RW-1:0];
			row_ok_q <= row_ok;
		end
	end

	// setup matrix: row-major, one write on the transaction, one registered read per scan cycle
	always_ff @(posedge clk) begin
		if (in_accept && (req.action == ACT_SETUP) && row_ok && col_ok) begin
			setup_mem[{req.row_task[RW-1:0], req.column_task[RW-1:0]}] <= tv;
		end
		if (issue) begin
			setup_rd_s1 <= setup_mem[{row_q, t_q[RW-1:0]}];
		end
	end

	// processing times
	always_ff @(posedge clk) begin
		if (in_accept && (req.action == ACT_PROC) && col_ok) begin
			proc_mem[req.column_task[RW-1:0]] <= tv;
		end
		if (issue) begin
			proc_rd_s1 <= proc_mem[t_q[RW-1:0]];
			task_s1    <= t_q;
		end
	end

	// every transaction restarts the compare unit, so non-query items report not found
	assign ctl.clear      = in_accept;
	assign ctl.cand_valid = cand_s1;

	mmcts_min_unit #(
		.TIME_BITS (TIME_BITS)
	) u_min (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cand_task  (task_s1),
		.setup_val  (setup_rd_s1),
		.proc_time  (proc_rd_s1),
		.best       (best)
	);

	// result register parts the scan from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			chosen_q <= best.task_id;
			cost_q   <= best.cost;
			found_q  <= best.found;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.chosen_task = chosen_q;
	assign rsp.arc_cost    = cost_q;
	assign rsp.found       = found_q;

`ifndef NO_ASSERTIONS
	// a candidate only reaches the compare unit in the cycle after a scan issue
	a_cand_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cand_s1 |-> $past(state_q) == S_SCAN)
		else $error("candidate outside scan");

	// the scheduled mask cannot move while a row is being scanned
	a_mask_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && $past(state_q) == S_SCAN) |-> $stable(sched_q))
		else $error("scheduled mask changed during scan");

	// a found task lies within the scanned range and is never task 0
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && best.found) |-> (best.task_id != '0 && best.task_id <= last_q))
		else $error("chosen task out of range");

	// one transaction in flight at a time: the input closes right after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !req.ready)
		else $error("input ready right after transaction");
`endif

endmodule

// File: rtl/mmcts_min_unit.sv
module mmcts_min_unit #(
	parameter int unsigned TIME_BITS = mmcts_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mmcts_pkg::scan_ctl_t        ctl,
	input  logic [mmcts_pkg::TASK_W-1:0] cand_task,
	input  logic [TIME_BITS-1:0]        setup_val,
	input  logic [TIME_BITS-1:0]        proc_time,
	output mmcts_pkg::best_t            best
);
	import mmcts_pkg::*;

	localparam int unsigned SUM_W = TIME_BITS + 1;
	localparam int unsigned EXT_W = (SUM_W > COST_W) ? SUM_W : COST_W;

	logic [SUM_W-1:0]  sum;
	logic              take;
	logic              any_q;
	logic [TASK_W-1:0] task_q;
	logic [SUM_W-1:0]  cost_q;
	logic [EXT_W-1:0]  cost_ext;

	// shared adder and comparator, strict less-than keeps the lowest index on ties
	assign sum  = SUM_W'(setup_val) + SUM_W'(proc_time);
	assign take = ctl.cand_valid && (!any_q || (sum < cost_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (ctl.clear) begin
			any_q <= 1'b0;
		end else if (take) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !ctl.clear) begin
			task_q <= cand_task;
			cost_q <= sum;
		end
	end

	assign cost_ext = EXT_W'(cost_q);

	always_comb begin
		best.found   = any_q;
		best.task_id = any_q ? task_q : '0;
		if (!any_q) begin
			best.cost = '0;
		end else if (cost_ext > EXT_W'(COST_MAX)) begin
			best.cost = COST_MAX;
		end else begin
			best.cost = cost_ext[COST_W-1:0];
		end
	end

endmodule

// File: test/masked_min_cost_task_select_top_test.sv
module masked_min_cost_task_select_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mmcts_pkg::*;

	// one row or column per task slot, task 0 included
	localparam int unsigned SIDE          = MAX_TASKS_DEF + 1;
	localparam int unsigned ACTION_LAST   = (1 << ACTION_W) - 1;
	localparam int unsigned RESET_CYCLES  = 11;
	// longer than the longest query, so this covers any item still in flight
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned ITEMS_TARGET  = 2000;
	localparam int unsigned PHASE_ITEMS   = 300;
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	// one input transaction
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [TASK_W-1:0]   row_task;
		logic [TASK_W-1:0]   column_task;
		logic [TIME_W-1:0]   time_value;
	} task_cmd_t;

	// one result transaction
	typedef struct packed {
		logic [TASK_W-1:0] chosen_task;
		logic [COST_W-1:0] arc_cost;
		logic              found;
	} sel_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [TASK_W-1:0] cfg_data;

	mmcts_in_if  req_if ();
	mmcts_out_if rsp_if ();

	masked_min_cost_task_select_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	// predictor state: a mirror of the block's stores, mask and task count
	logic [TIME_W-1:0] setup_tbl [SIDE][SIDE];
	logic [TIME_W-1:0] proc_time [SIDE];
	// which entries hold a written value; queries only go to fully written rows
	bit                setup_known [SIDE][SIDE];
	bit                proc_known [SIDE];
	logic [MASK_W-1:0] sched_mask;
	logic [TASK_W-1:0] task_count_cfg;

	// results still owed by the block, oldest first
	sel_result_t pending_q[$];

	int unsigned fail_count;
	int unsigned counted_items;
	int unsigned query_count;
	int unsigned empty_query_count;
	int unsigned config_count;
	int unsigned cycle_count;
	// when set the sender runs back to back
	bit          tx_no_gap;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// times lean toward the extremes and toward small values so that ties show up
	function automatic logic [TIME_W-1:0] pick_time();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return TIME_W'($urandom_range(0, 7));
			default: return TIME_W'($urandom_range(0, (1 << TIME_W) - 1));
		endcase
	endfunction

	function automatic task_cmd_t make_cmd(input logic [ACTION_W-1:0] action,
			input int unsigned row, input int unsigned col, input logic [TIME_W-1:0] tv);
		task_cmd_t cmd;
		cmd.action      = action;
		cmd.row_task    = TASK_W'(row);
		cmd.column_task = TASK_W'(col);
		cmd.time_value  = tv;
		return cmd;
	endfunction

	// true when a query of this row reads only written entries
	function automatic bit row_loaded(input int unsigned row);
		for (int unsigned t = 1; t <= task_count_cfg; t++) begin
			if (!setup_known[row][t] || !proc_known[t])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// applies one transaction to the mirror and returns the result it must give
	function automatic sel_result_t predict_selection(input task_cmd_t cmd);
		sel_result_t res;
		logic [COST_W:0] cost;
		logic [COST_W:0] best;
		int unsigned last;
		res  = '0;
		best = '0;
		case (cmd.action)
			ACT_SETUP: begin
				setup_tbl[cmd.row_task][cmd.column_task]   = cmd.time_value;
				setup_known[cmd.row_task][cmd.column_task] = 1'b1;
			end
			ACT_PROC: begin
				proc_time[cmd.column_task]  = cmd.time_value;
				proc_known[cmd.column_task] = 1'b1;
			end
			ACT_CLEAR: sched_mask = '0;
			ACT_MARK: sched_mask[cmd.column_task] = 1'b1;
			ACT_QUERY: begin
				last = (task_count_cfg > MAX_TASKS_DEF) ? MAX_TASKS_DEF : task_count_cfg;
				// task 0 is never a candidate; strict compare keeps the lowest index on a tie
				for (int unsigned t = 1; t <= last; t++) begin
					if (!sched_mask[t]) begin
						cost = setup_tbl[cmd.row_task][t] + proc_time[t];
						if (!res.found || cost < best) begin
							res.found       = 1'b1;
							res.chosen_task = TASK_W'(t);
							best            = cost;
						end
					end
				end
				res.arc_cost = (best > COST_MAX) ? COST_MAX : best[COST_W-1:0];
			end
			default: ;
		endcase
		return res;
	endfunction

	// sends one transaction; called at a rising edge, returns at the edge that took it
	task automatic send_cmd(input task_cmd_t cmd);
		int unsigned gap;
		sel_result_t res;
		gap = tx_no_gap ? 0 : pick_gap();
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.action      <= cmd.action;
		req_if.row_task    <= cmd.row_task;
		req_if.column_task <= cmd.column_task;
		req_if.time_value  <= cmd.time_value;
		do
			@(posedge clk);
		while (!req_if.ready);
		res = predict_selection(cmd);
		pending_q = {pending_q, res};
		// unknown actions are ignored by the block and do not count
		if (cmd.action <= ACT_QUERY)
			counted_items++;
		if (cmd.action == ACT_QUERY) begin
			query_count++;
			if (!res.found)
				empty_query_count++;
		end
	endtask

	// stop sending and let every owed result come back
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever with the block idle
	task automatic set_task_count(input int unsigned count);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= TASK_W'(count);
		@(posedge clk);
		cfg_we         <= 1'b0;
		task_count_cfg = TASK_W'(count);
		config_count++;
	endtask

	// random action of any kind, queries only to rows that are fully written
	task automatic send_noise();
		int unsigned row;
		row = $urandom_range(0, MAX_TASKS_DEF);
		case ($urandom_range(0, 5))
			0: send_cmd(make_cmd(ACT_SETUP, row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
			1: send_cmd(make_cmd(ACT_PROC, row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
			2: send_cmd(make_cmd(ACT_MARK, row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
			3: send_cmd(make_cmd(ACT_CLEAR, row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
			4: send_cmd(make_cmd(ACTION_W'(ACT_QUERY + $urandom_range(1, ACTION_LAST - ACT_QUERY)),
				row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
			default: begin
				if (row_loaded(row))
					send_cmd(make_cmd(ACT_QUERY, row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
				else
					send_cmd(make_cmd(ACT_MARK, row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
			end
		endcase
	endtask

	// load a row, shape the scheduled set, then query the row
	task automatic run_select_sequence();
		int unsigned row;
		int unsigned last;
		row  = $urandom_range(0, MAX_TASKS_DEF);
		last = task_count_cfg;
		tx_no_gap = ($urandom_range(0, 4) == 0);
		for (int unsigned t = 1; t <= last; t++) begin
			if (!setup_known[row][t] || $urandom_range(0, 3) == 0)
				send_cmd(make_cmd(ACT_SETUP, row, t, pick_time()));
		end
		for (int unsigned t = 1; t <= last; t++) begin
			if (!proc_known[t] || $urandom_range(0, 7) == 0)
				send_cmd(make_cmd(ACT_PROC, $urandom_range(0, MAX_TASKS_DEF), t, pick_time()));
		end
		if ($urandom_range(0, 3) == 0)
			send_cmd(make_cmd(ACT_CLEAR, row, 0, pick_time()));
		if ($urandom_range(0, 9) == 0) begin
			// every task taken: the query comes back empty unless noise clears the mask first
			for (int unsigned t = 1; t <= last; t++)
				send_cmd(make_cmd(ACT_MARK, row, t, pick_time()));
		end else begin
			repeat ($urandom_range(0, 3))
				send_cmd(make_cmd(ACT_MARK, row, $urandom_range(0, last), pick_time()));
		end
		if ($urandom_range(0, 4) == 0)
			send_noise();
		send_cmd(make_cmd(ACT_QUERY, row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
		// follow-up: take one more task away and ask again
		if ($urandom_range(0, 2) == 0) begin
			send_cmd(make_cmd(ACT_MARK, row, $urandom_range(1, MAX_TASKS_DEF), pick_time()));
			send_cmd(make_cmd(ACT_QUERY, row, $urandom_range(0, MAX_TASKS_DEF), pick_time()));
		end
		tx_no_gap = 1'b0;
	endtask

	// row 0 with three tasks: tie on the lowest index, the largest cost, an empty
	// result, marking task 0, clear, an ignored action and writes at the far indexes
	task automatic test_directed_costs();
		set_task_count(3);
		send_cmd(make_cmd(ACT_SETUP, 0, 1, '1));
		send_cmd(make_cmd(ACT_SETUP, 0, 2, '0));
		send_cmd(make_cmd(ACT_SETUP, 0, 3, '0));
		send_cmd(make_cmd(ACT_PROC, 0, 1, '1));
		send_cmd(make_cmd(ACT_PROC, 0, 2, TIME_W'(5)));
		send_cmd(make_cmd(ACT_PROC, 0, 3, TIME_W'(5)));
		send_cmd(make_cmd(ACT_QUERY, 0, 0, '0));
		send_cmd(make_cmd(ACT_MARK, 0, 2, '0));
		send_cmd(make_cmd(ACT_QUERY, 0, 0, '0));
		send_cmd(make_cmd(ACT_MARK, 0, 3, '0));
		send_cmd(make_cmd(ACT_QUERY, 0, 0, '0));
		send_cmd(make_cmd(ACT_MARK, 0, 1, '0));
		send_cmd(make_cmd(ACT_QUERY, 0, 0, '0));
		send_cmd(make_cmd(ACT_MARK, 0, 0, '0));
		send_cmd(make_cmd(ACT_CLEAR, 0, 0, '0));
		send_cmd(make_cmd(ACT_QUERY, 0, 0, '0));
		send_cmd(make_cmd(ACTION_W'(ACTION_LAST), MAX_TASKS_DEF, MAX_TASKS_DEF, '1));
		send_cmd(make_cmd(ACT_SETUP, MAX_TASKS_DEF, MAX_TASKS_DEF, '1));
		send_cmd(make_cmd(ACT_PROC, MAX_TASKS_DEF, 0, '1));
	endtask

	// task_count at zero gives no candidate, at one only task 1 is scanned
	task automatic test_count_limits();
		set_task_count(0);
		send_cmd(make_cmd(ACT_QUERY, 0, 0, '0));
		set_task_count(1);
		send_cmd(make_cmd(ACT_QUERY, 0, 0, '0));
		send_cmd(make_cmd(ACT_SETUP, MAX_TASKS_DEF, 1, '0));
		send_cmd(make_cmd(ACT_QUERY, MAX_TASKS_DEF, 0, '0));
	endtask

	// phases of random traffic, each under its own task_count, the full count first
	task automatic test_random_traffic();
		int unsigned count;
		int unsigned phase_end;
		bit          first_phase;
		first_phase = 1'b1;
		while (counted_items < ITEMS_TARGET) begin
			case ($urandom_range(0, 4))
				0: count = MAX_TASKS_DEF;
				1: count = 1;
				default: count = $urandom_range(2, 8);
			endcase
			if (first_phase)
				count = MAX_TASKS_DEF;
			first_phase = 1'b0;
			set_task_count(count);
			phase_end = counted_items + PHASE_ITEMS;
			while (counted_items < phase_end && counted_items < ITEMS_TARGET) begin
				if ($urandom_range(0, 3) == 0)
					send_noise();
				else
					run_select_sequence();
				// now and then hold off until the block has answered everything
				if ($urandom_range(0, 19) == 0)
					wait_drained();
			end
		end
	endtask

	// result side: ready with random stalls, short and now and then long stall-free runs in between
	initial begin
		int unsigned run;
		int unsigned stall;
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
			rsp_if.ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// compare every result transaction against the oldest prediction
	always @(posedge clk) begin
		sel_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none, actual task %0d cost %0d found %0b",
					$time, rsp_if.chosen_task, rsp_if.arc_cost, rsp_if.found);
			end else begin
				want = pending_q.pop_front();
				if (rsp_if.chosen_task !== want.chosen_task) begin
					fail_count++;
					$display("%0t: chosen_task expected %0d actual %0d",
						$time, want.chosen_task, rsp_if.chosen_task);
				end
				if (rsp_if.arc_cost !== want.arc_cost) begin
					fail_count++;
					$display("%0t: arc_cost expected %0d actual %0d",
						$time, want.arc_cost, rsp_if.arc_cost);
				end
				if (rsp_if.found !== want.found) begin
					fail_count++;
					$display("%0t: found expected %0b actual %0b",
						$time, want.found, rsp_if.found);
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still owed", cycle_count, pending_q.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_data           <= '0;
		req_if.valid       <= 1'b0;
		req_if.action      <= '0;
		req_if.row_task    <= '0;
		req_if.column_task <= '0;
		req_if.time_value  <= '0;
		// mirror of the reset state; the stores start out unwritten
		sched_mask        = '0;
		task_count_cfg    = TASK_COUNT_RST;
		tx_no_gap         = 1'b0;
		fail_count        = 0;
		counted_items     = 0;
		query_count       = 0;
		empty_query_count = 0;
		config_count      = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_costs();
		test_count_limits();
		test_random_traffic();

		// all owed results in, then a quiet tail to catch anything extra
		wait_drained();

		$display("sent %0d transactions: %0d queries, %0d of them with no task left",
			counted_items, query_count, empty_query_count);
		$display("task_count written %0d times, from 0 up to %0d", config_count, MAX_TASKS_DEF);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/mmcts_pkg.sv
rtl/mmcts_if.sv
rtl/mmcts_min_unit.sv
rtl/masked_min_cost_task_select_top.sv
test/masked_min_cost_task_select_top_test.sv
